// ----- rtl/signal_block_statistics_top_macros.svh -----
// Assertion macros for the record statistics block.
// Each macro expects the signals clk and arst_n in the scope where it is used.
`ifndef SIGNAL_BLOCK_STATISTICS_TOP_MACROS_SVH
`define SIGNAL_BLOCK_STATISTICS_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sbs_pkg.sv -----
package sbs_pkg;

	// Default parameter values.
	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int MAX_COUNT_DEF     = 65536;
	localparam int FRACTION_BITS_DEF = 8;

	// Number of finished records that may wait for the back end.
	localparam int QUEUE_DEPTH = 2;

	// Fixed widths of the result fields.
	localparam int OUT_W       = 24;
	localparam int COUNT_OUT_W = 17;

	// Width of a counter that can hold max_count itself.
	function automatic int cnt_width(input int max_count);
		return $clog2(max_count + 1);
	endfunction

	// Width of the signed running sum.
	function automatic int sum_width(input int sample_bits, input int max_count);
		return sample_bits + cnt_width(max_count);
	endfunction

	// Width of the unsigned running sum of squares.
	function automatic int sq_width(input int sample_bits, input int max_count);
		return 2 * sample_bits - 2 + cnt_width(max_count);
	endfunction

endpackage

// ----- rtl/sbs_queue.sv -----
`include "signal_block_statistics_top_macros.svh"

module sbs_queue #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Record storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`SBS_ASSERT_NOW(a_queue_no_overrun, push, !full, "record pushed into a full queue")
	`SBS_ASSERT_NEXT(a_queue_fill_up, push && !pop, count_q == $past(count_q) + 1'b1,
		"queue level did not rise after a push")

endmodule

// ----- rtl/sbs_front.sv -----
`include "signal_block_statistics_top_macros.svh"

module sbs_front #(
	parameter int SAMPLE_BITS   = sbs_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_COUNT     = sbs_pkg::MAX_COUNT_DEF,
	parameter int SUM_W         = sbs_pkg::sum_width(SAMPLE_BITS, MAX_COUNT),
	parameter int SQ_W          = sbs_pkg::sq_width(SAMPLE_BITS, MAX_COUNT),
	parameter int CNT_W         = sbs_pkg::cnt_width(MAX_COUNT)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	input  logic                          rec_full,
	output logic                          rec_push,
	output logic signed [SUM_W-1:0]       rec_sum,
	output logic        [SQ_W-1:0]        rec_sumsq,
	output logic        [CNT_W-1:0]       rec_count,
	output logic                          rec_ovf
);

	localparam int SQR_W = 2 * SAMPLE_BITS - 1;

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic        [SQR_W-1:0]       sq_s1;
	logic                          last_s1;

	logic signed [2*SAMPLE_BITS-1:0] sq_full;
	logic                            adv;
	logic                            take;
	logic                            sat;

	logic signed [SUM_W-1:0] sum_q;
	logic        [SQ_W-1:0]  sumsq_q;
	logic        [CNT_W-1:0] count_q;
	logic                    ovf_q;

	logic signed [SUM_W-1:0] sum_nx;
	logic        [SQ_W-1:0]  sumsq_nx;
	logic        [CNT_W-1:0] count_nx;
	logic                    ovf_nx;

	// Stage 1 moves on unless it holds a record end that the queue cannot take.
	assign adv      = !valid_s1 || !last_s1 || !rec_full;
	assign in_ready = adv;
	assign take     = valid_s1 && adv;
	assign sq_full  = sample * sample;

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload: the sample and its square.
	always_ff @(posedge clk) begin
		if (in_valid && adv) begin
			smp_s1  <= sample;
			sq_s1   <= sq_full[SQR_W-1:0];
			last_s1 <= last;
		end
	end

	// Accumulation, frozen once the count has reached its limit.
	always_comb begin
		sat      = (count_q >= CNT_W'(MAX_COUNT));
		sum_nx   = sat ? sum_q : sum_q + SUM_W'(smp_s1);
		sumsq_nx = sat ? sumsq_q : sumsq_q + SQ_W'(sq_s1);
		count_nx = sat ? count_q : count_q + 1'b1;
		ovf_nx   = ovf_q | sat;
	end

	// Running sums; a record end hands them over and starts afresh.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			sumsq_q <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			if (last_s1) begin
				sum_q   <= '0;
				sumsq_q <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				sum_q   <= sum_nx;
				sumsq_q <= sumsq_nx;
				count_q <= count_nx;
				ovf_q   <= ovf_nx;
			end
		end
	end

	assign rec_push  = take && last_s1;
	assign rec_sum   = sum_nx;
	assign rec_sumsq = sumsq_nx;
	assign rec_count = count_nx;
	assign rec_ovf   = ovf_nx;

	`SBS_ASSERT_NOW(a_front_count_limit, 1'b1, count_q <= CNT_W'(MAX_COUNT),
		"sample count ran past its limit")

endmodule

// ----- rtl/sbs_divider.sv -----
module sbs_divider #(
	parameter int NUM_W = 8,
	parameter int DEN_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quot,
	output logic [DEN_W-1:0] rem
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0]  quot_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;

	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;

	// One restoring step: bring down the next dividend bit and try the subtract.
	always_comb begin
		trial = {rem_q, quot_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	// Step sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(NUM_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Quotient and remainder shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= numer;
			rem_q  <= '0;
			den_q  <= denom;
		end else if (busy_q) begin
			quot_q <= {quot_q[NUM_W-2:0], ge};
			rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ----- rtl/sbs_isqrt.sv -----
module sbs_isqrt #(
	parameter int ROOT_W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [2*ROOT_W-1:0] radicand,
	output logic                done,
	output logic [ROOT_W-1:0]   root
);

	localparam int STEP_W = $clog2(ROOT_W + 1);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [2*ROOT_W-1:0] rad_q;
	logic [ROOT_W:0]     rem_q;
	logic [ROOT_W-1:0]   root_q;

	logic [ROOT_W+1:0]   rem_sh;
	logic [ROOT_W+1:0]   trial;
	logic [ROOT_W+1:0]   diff;
	logic                ge;

	// One digit step: two radicand bits in, one root bit out.
	always_comb begin
		rem_sh = {rem_q[ROOT_W-1:0], rad_q[2*ROOT_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		diff   = rem_sh - trial;
		ge     = (rem_sh >= trial);
	end

	// Step sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(ROOT_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Radicand, partial remainder and root.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- rtl/sbs_back.sv -----
`include "signal_block_statistics_top_macros.svh"

module sbs_back #(
	parameter int SAMPLE_BITS   = sbs_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_COUNT     = sbs_pkg::MAX_COUNT_DEF,
	parameter int FRACTION_BITS = sbs_pkg::FRACTION_BITS_DEF,
	parameter int SUM_W         = sbs_pkg::sum_width(SAMPLE_BITS, MAX_COUNT),
	parameter int SQ_W          = sbs_pkg::sq_width(SAMPLE_BITS, MAX_COUNT),
	parameter int CNT_W         = sbs_pkg::cnt_width(MAX_COUNT)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 rec_valid,
	output logic                                 rec_pop,
	input  logic signed [SUM_W-1:0]              rec_sum,
	input  logic        [SQ_W-1:0]               rec_sumsq,
	input  logic        [CNT_W-1:0]              rec_count,
	input  logic                                 rec_ovf,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [sbs_pkg::OUT_W-1:0]       mean_value,
	output logic        [sbs_pkg::OUT_W-1:0]       rms_value,
	output logic        [sbs_pkg::OUT_W-1:0]       std_dev,
	output logic        [sbs_pkg::OUT_W-1:0]       amplitude,
	output logic        [sbs_pkg::COUNT_OUT_W-1:0] sample_count,
	output logic                                 overflow
);

	localparam int MAG_W  = SUM_W - 1;
	localparam int PROD_W = CNT_W + SQ_W;
	localparam int DIV_W  = PROD_W + 2 * FRACTION_BITS;
	localparam int RW     = SAMPLE_BITS + FRACTION_BITS;
	localparam int OW     = sbs_pkg::OUT_W;
	localparam int NW     = sbs_pkg::COUNT_OUT_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MEAN,
		S_RMS,
		S_SQ_RMS,
		S_SQ_AMP,
		S_MUL_NS,
		S_MUL_SQ,
		S_VAR1,
		S_VAR2,
		S_SQ_STD,
		S_DONE
	} state_t;

	state_t state_q;

	// Record under work.
	logic [MAG_W-1:0] mag_q;
	logic             neg_q;
	logic [SQ_W-1:0]  sumsq_q;
	logic [CNT_W-1:0] n_q;
	logic             ovf_q;

	// Shared arithmetic units.
	logic              div_start_q;
	logic [DIV_W-1:0]  div_num_q;
	logic              div_done;
	logic [DIV_W-1:0]  div_quot;
	logic [CNT_W-1:0]  div_rem;
	logic              sqrt_start_q;
	logic [2*RW-1:0]   sqrt_rad_q;
	logic              sqrt_done;
	logic [RW-1:0]     sqrt_root;
	logic              div_go;
	logic              sqrt_go;

	// Shift-add multiplier.
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] mcand_q;
	logic [MAG_W-1:0]  mplier_q;

	// Results under work.
	logic [2*RW-1:0]   amp_rad_q;
	logic [OW-1:0]     mean_q;
	logic [OW-1:0]     rms_q;
	logic [OW-1:0]     amp_q;
	logic [OW-1:0]     std_q;

	// Output register.
	logic              out_valid_q;
	logic [OW-1:0]     mean_out_q;
	logic [OW-1:0]     rms_out_q;
	logic [OW-1:0]     std_out_q;
	logic [OW-1:0]     amp_out_q;
	logic [NW-1:0]     count_out_q;
	logic              ovf_out_q;

	logic [MAG_W-1:0]        rec_mag;
	logic [DIV_W-1:0]        mean_mag;
	logic signed [DIV_W-1:0] mean_full;
	logic                    half_up;

	sbs_divider #(
		.NUM_W(DIV_W),
		.DEN_W(CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.numer  (div_num_q),
		.denom  (n_q),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	sbs_isqrt #(
		.ROOT_W(RW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start_q),
		.radicand (sqrt_rad_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// Magnitude of the incoming sum and the floored, signed mean.
	always_comb begin
		rec_mag   = rec_sum[SUM_W-1] ? MAG_W'(-rec_sum) : MAG_W'(rec_sum);
		mean_mag  = div_quot + DIV_W'(neg_q && (div_rem != '0));
		mean_full = neg_q ? -$signed(mean_mag) : $signed(mean_mag);
		half_up   = ({div_rem, 1'b0} >= {1'b0, n_q});
	end

	// Start pulses for the shared divider and square root.
	always_comb begin
		div_go  = 1'b0;
		sqrt_go = 1'b0;
		case (state_q)
			S_IDLE:   div_go  = rec_valid;
			S_MEAN:   div_go  = div_done;
			S_RMS:    sqrt_go = div_done;
			S_SQ_RMS: sqrt_go = sqrt_done;
			S_MUL_SQ: div_go  = (mplier_q == '0);
			S_VAR1:   div_go  = div_done;
			S_VAR2:   sqrt_go = div_done;
			default:  div_go  = 1'b0;
		endcase
	end

	assign rec_pop = rec_valid && (state_q == S_IDLE);

	// Sequencer: mean, RMS, amplitude, then n*sumsq - sum^2 and the deviation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mag_q        <= '0;
			neg_q        <= 1'b0;
			sumsq_q      <= '0;
			n_q          <= '0;
			ovf_q        <= 1'b0;
			div_start_q  <= 1'b0;
			div_num_q    <= '0;
			sqrt_start_q <= 1'b0;
			sqrt_rad_q   <= '0;
			acc_q        <= '0;
			mcand_q      <= '0;
			mplier_q     <= '0;
			amp_rad_q    <= '0;
			mean_q       <= '0;
			rms_q        <= '0;
			amp_q        <= '0;
			std_q        <= '0;
			out_valid_q  <= 1'b0;
			mean_out_q   <= '0;
			rms_out_q    <= '0;
			std_out_q    <= '0;
			amp_out_q    <= '0;
			count_out_q  <= '0;
			ovf_out_q    <= 1'b0;
		end else begin
			div_start_q  <= div_go;
			sqrt_start_q <= sqrt_go;
			// A finished record enters the output register once the previous result has left.
			if ((state_q == S_DONE) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (rec_valid) begin
						mag_q       <= rec_mag;
						neg_q       <= rec_sum[SUM_W-1];
						sumsq_q     <= rec_sumsq;
						n_q         <= rec_count;
						ovf_q       <= rec_ovf;
						div_num_q   <= DIV_W'(rec_mag) << FRACTION_BITS;
						state_q     <= S_MEAN;
					end
				end
				S_MEAN: begin
					if (div_done) begin
						mean_q      <= OW'(mean_full);
						div_num_q   <= DIV_W'(sumsq_q) << (2 * FRACTION_BITS);
						state_q     <= S_RMS;
					end
				end
				S_RMS: begin
					if (div_done) begin
						sqrt_rad_q   <= div_quot[2*RW-1:0];
						amp_rad_q    <= {div_quot[2*RW-2:0], half_up};
						state_q      <= S_SQ_RMS;
					end
				end
				S_SQ_RMS: begin
					if (sqrt_done) begin
						rms_q        <= OW'(sqrt_root);
						sqrt_rad_q   <= amp_rad_q;
						state_q      <= S_SQ_AMP;
					end
				end
				S_SQ_AMP: begin
					if (sqrt_done) begin
						amp_q    <= OW'(sqrt_root);
						acc_q    <= '0;
						mcand_q  <= PROD_W'(sumsq_q);
						mplier_q <= MAG_W'(n_q);
						state_q  <= S_MUL_NS;
					end
				end
				S_MUL_NS: begin
					if (mplier_q == '0) begin
						mcand_q  <= PROD_W'(mag_q);
						mplier_q <= mag_q;
						state_q  <= S_MUL_SQ;
					end else begin
						if (mplier_q[0]) begin
							acc_q <= acc_q + mcand_q;
						end
						mcand_q  <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
					end
				end
				S_MUL_SQ: begin
					// n*sumsq never falls below sum^2, so the running difference stays non-negative.
					if (mplier_q == '0) begin
						div_num_q   <= DIV_W'(acc_q) << (2 * FRACTION_BITS);
						state_q     <= S_VAR1;
					end else begin
						if (mplier_q[0]) begin
							acc_q <= acc_q - mcand_q;
						end
						mcand_q  <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
					end
				end
				S_VAR1: begin
					if (div_done) begin
						div_num_q   <= div_quot;
						state_q     <= S_VAR2;
					end
				end
				S_VAR2: begin
					if (div_done) begin
						sqrt_rad_q   <= div_quot[2*RW-1:0];
						state_q      <= S_SQ_STD;
					end
				end
				S_SQ_STD: begin
					if (sqrt_done) begin
						std_q   <= OW'(sqrt_root);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						mean_out_q  <= mean_q;
						rms_out_q   <= rms_q;
						std_out_q   <= std_q;
						amp_out_q   <= amp_q;
						count_out_q <= NW'(n_q);
						ovf_out_q   <= ovf_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign mean_value   = mean_out_q;
	assign rms_value    = rms_out_q;
	assign std_dev      = std_out_q;
	assign amplitude    = amp_out_q;
	assign sample_count = count_out_q;
	assign overflow     = ovf_out_q;

	`SBS_ASSERT_NOW(a_back_div_state, div_done,
		(state_q == S_MEAN) || (state_q == S_RMS) || (state_q == S_VAR1) || (state_q == S_VAR2),
		"divider finished outside a division step")
	`SBS_ASSERT_NOW(a_back_std_below_rms, out_valid_q, std_out_q <= rms_out_q,
		"standard deviation exceeds the RMS value")
	`SBS_ASSERT_NOW(a_back_amp_above_rms, out_valid_q, amp_out_q >= rms_out_q,
		"amplitude below the RMS value")

endmodule

// ----- rtl/signal_block_statistics_top.sv -----
// Samples are taken one per cycle; a record's results follow its last sample at a pace set by the
// bit-serial divider, whose width is DW = CNT_W + SQ_W + 2*FRACTION_BITS.
// The back end handles one record at a time; up to two finished records wait in a queue, and
// input stalls only when that queue is full while a record end is pending.
// Reset (arst_n low, asynchronous) clears the running sums, the queue and all pending results.
module signal_block_statistics_top #(
	parameter int SAMPLE_BITS   = sbs_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_COUNT     = sbs_pkg::MAX_COUNT_DEF,
	parameter int FRACTION_BITS = sbs_pkg::FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [sbs_pkg::OUT_W-1:0]       mean_value,
	output logic        [sbs_pkg::OUT_W-1:0]       rms_value,
	output logic        [sbs_pkg::OUT_W-1:0]       std_dev,
	output logic        [sbs_pkg::OUT_W-1:0]       amplitude,
	output logic        [sbs_pkg::COUNT_OUT_W-1:0] sample_count,
	output logic                                 overflow
);

	localparam int CNT_W = sbs_pkg::cnt_width(MAX_COUNT);
	localparam int SUM_W = sbs_pkg::sum_width(SAMPLE_BITS, MAX_COUNT);
	localparam int SQ_W  = sbs_pkg::sq_width(SAMPLE_BITS, MAX_COUNT);
	localparam int REC_W = SUM_W + SQ_W + CNT_W + 1;

	logic                    rec_full;
	logic                    rec_push;
	logic signed [SUM_W-1:0] push_sum;
	logic        [SQ_W-1:0]  push_sumsq;
	logic        [CNT_W-1:0] push_count;
	logic                    push_ovf;
	logic        [REC_W-1:0] push_data;

	logic                    rec_pop;
	logic                    rec_valid;
	logic        [REC_W-1:0] pop_data;
	logic signed [SUM_W-1:0] pop_sum;
	logic        [SQ_W-1:0]  pop_sumsq;
	logic        [CNT_W-1:0] pop_count;
	logic                    pop_ovf;

	// Front end: per-sample accumulation.
	sbs_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_COUNT   (MAX_COUNT),
		.SUM_W       (SUM_W),
		.SQ_W        (SQ_W),
		.CNT_W       (CNT_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.last      (last),
		.rec_full  (rec_full),
		.rec_push  (rec_push),
		.rec_sum   (push_sum),
		.rec_sumsq (push_sumsq),
		.rec_count (push_count),
		.rec_ovf   (push_ovf)
	);

	// Finished records travel packed through the queue.
	assign push_data = {push_sum, push_sumsq, push_count, push_ovf};
	assign {pop_sum, pop_sumsq, pop_count, pop_ovf} = pop_data;

	sbs_queue #(
		.WIDTH (REC_W),
		.DEPTH (sbs_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.push_data (push_data),
		.full      (rec_full),
		.pop       (rec_pop),
		.pop_valid (rec_valid),
		.pop_data  (pop_data)
	);

	// Back end: per-record division and roots.
	sbs_back #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.MAX_COUNT     (MAX_COUNT),
		.FRACTION_BITS (FRACTION_BITS),
		.SUM_W         (SUM_W),
		.SQ_W          (SQ_W),
		.CNT_W         (CNT_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_valid    (rec_valid),
		.rec_pop      (rec_pop),
		.rec_sum      (pop_sum),
		.rec_sumsq    (pop_sumsq),
		.rec_count    (pop_count),
		.rec_ovf      (pop_ovf),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mean_value   (mean_value),
		.rms_value    (rms_value),
		.std_dev      (std_dev),
		.amplitude    (amplitude),
		.sample_count (sample_count),
		.overflow     (overflow)
	);

endmodule
